// File: rtl/core/cri_pkg.sv
// Shared types, constants and helpers of the chunk ring index.
// No dependencies; imported by cri_ctrl and chunk_ring_index_core.
package cri_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LOG2_W = 5;
	localparam int HANDLE_W = 32;
	localparam int WORD_W = 64;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_POP = 2'd1;
	localparam logic [1:0] KIND_FIND_SEQ = 2'd2;
	localparam logic [1:0] KIND_FIND_TIME = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POP_RD,
		S_SEQ_FRONT,
		S_SEQ_BACK,
		S_SEQ_CHECK,
		S_SEQ_STEP,
		S_TS_LOOP,
		S_TS_CMP,
		S_FETCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] stamp;
	} rec_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [HANDLE_W-1:0] handle;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] stamp;
		logic [WORD_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [HANDLE_W-1:0] handle;
	} res_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		rec_t wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic [CNT_W-1:0] fill;
	} stat_t;

	// Physical slot of logical offset off from base, wrapping at CAPACITY.
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] slot);
		return (slot == IDX_W'(CAPACITY - 1)) ? '0 : slot + 1'b1;
	endfunction

endpackage

// File: rtl/core/cri_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module cri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/cri_ctrl.sv
// Sequencer of the chunk ring index: ring pointers, request decode, sequence
// lookup and timestamp binary search over the record RAM. Uses cri_pkg.
module cri_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cri_pkg::item_t in_item,
	input logic [cri_pkg::LOG2_W-1:0] batch_log2,
	output cri_pkg::mem_req_t mem_req,
	input cri_pkg::rec_t rd_rec,
	output logic res_valid,
	input logic res_ready,
	output cri_pkg::res_t res,
	output cri_pkg::stat_t stat
);
	import cri_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0] front_q, back_q;
	logic [CNT_W-1:0] fill_q;

	item_t item_q;
	logic [1:0] status_q;
	logic [HANDLE_W-1:0] found_q;
	logic [WORD_W-1:0] first_q, last_q, diff_q;
	logic [IDX_W-1:0] lo_q, hi_q, mid_q;

	logic full, empty, key_out, step_over, ts_more;
	logic [WORD_W-1:0] steps, batch_mask;
	logic [CNT_W-1:0] pos_cnt;
	logic [IDX_W:0] span;
	logic [IDX_W-1:0] mid;

	// Newest logical position for a non-empty ring
	function automatic logic [IDX_W-1:0] pos_cnt_last(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] last;
		last = cnt - CNT_W'(1);
		return last[IDX_W-1:0];
	endfunction

	assign full = (fill_q >= CNT_W'(CAPACITY));
	assign empty = (fill_q == '0);
	assign batch_mask = (WORD_W'(1) << batch_log2) - WORD_W'(1);
	assign key_out = (item_q.key < first_q) || (item_q.key > last_q);
	assign steps = diff_q >> batch_log2;
	assign step_over = (|steps[WORD_W-1:CNT_W]) || (steps[CNT_W-1:0] >= fill_q);
	assign pos_cnt = fill_q - CNT_W'(1) - steps[CNT_W-1:0];
	assign ts_more = (lo_q < hi_q);
	assign span = {1'b0, hi_q} - {1'b0, lo_q} + (IDX_W+1)'(1);
	assign mid = lo_q + span[IDX_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		mem_req.we = 1'b0;
		mem_req.waddr = slot_inc(back_q);
		mem_req.wdata = '{handle: item_q.handle, seq: item_q.seq, stamp: item_q.stamp};
		mem_req.raddr = front_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				if (item_q.kind == KIND_APPEND) begin
					mem_req.we = !full;
				end else if (!empty) begin
					unique case (item_q.kind)
						KIND_POP: state_d = S_POP_RD;
						KIND_FIND_SEQ: state_d = S_SEQ_FRONT;
						default: state_d = S_TS_LOOP;
					endcase
				end
			end
			S_POP_RD: state_d = S_DONE;
			S_SEQ_FRONT: begin
				mem_req.raddr = back_q;
				state_d = S_SEQ_BACK;
			end
			S_SEQ_BACK: state_d = S_SEQ_CHECK;
			S_SEQ_CHECK: state_d = key_out ? S_DONE : S_SEQ_STEP;
			S_SEQ_STEP: begin
				mem_req.raddr = slot_add(front_q, pos_cnt[IDX_W-1:0]);
				state_d = step_over ? S_DONE : S_FETCH;
			end
			S_TS_LOOP: begin
				mem_req.raddr = slot_add(front_q, ts_more ? mid : lo_q);
				state_d = ts_more ? S_TS_CMP : S_FETCH;
			end
			S_TS_CMP: state_d = S_TS_LOOP;
			S_FETCH: state_d = S_DONE;
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= IDX_W'(CAPACITY - 1);
			fill_q <= '0;
		end else if (state_q == S_DISPATCH && item_q.kind == KIND_APPEND && !full) begin
			back_q <= slot_inc(back_q);
			fill_q <= fill_q + 1'b1;
		end else if (state_q == S_POP_RD) begin
			front_q <= slot_inc(front_q);
			fill_q <= fill_q - 1'b1;
		end
	end

	// Request payload and search registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q <= in_item;
				status_q <= ST_OK;
				found_q <= '0;
			end
			S_DISPATCH: begin
				lo_q <= '0;
				hi_q <= pos_cnt_last(fill_q);
				if (item_q.kind == KIND_APPEND) begin
					if (full) begin
						status_q <= ST_FULL;
					end
				end else if (empty) begin
					status_q <= ST_EMPTY;
				end
			end
			S_POP_RD: found_q <= rd_rec.handle;
			S_SEQ_FRONT: first_q <= rd_rec.seq;
			S_SEQ_BACK: last_q <= rd_rec.seq + batch_mask;
			S_SEQ_CHECK: begin
				diff_q <= last_q - item_q.key;
				if (key_out) begin
					status_q <= ST_RANGE;
				end
			end
			S_SEQ_STEP: begin
				if (step_over) begin
					status_q <= ST_RANGE;
				end
			end
			S_TS_LOOP: mid_q <= mid;
			S_TS_CMP: begin
				if (rd_rec.stamp <= item_q.key) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - 1'b1;
				end
			end
			S_FETCH: found_q <= rd_rec.handle;
			default: ;
		endcase
	end

	assign res = '{status: status_q, handle: found_q};
	assign stat = '{busy: (state_q != S_IDLE), fill: fill_q};

endmodule

// File: rtl/core/chunk_ring_index_core.sv
// Top level of the chunk ring index: stream ports, configuration register,
// result register, record RAM and sequencer. Uses cri_pkg, cri_ram, cri_ctrl.
//
// Usage:
//   Request words enter on s_* (s_tuser = kind), one result word per request
//   leaves on m_* (m_tuser = status, m_tdata = found handle). The ring holds
//   up to CAPACITY (64) records of handle, first sequence and first timestamp.
//   cfg_* writes batch_size_log2; cfg_ready is always high; write only while
//   the block is idle.
// Requests are handled one at a time, each read of the record RAM going through
//   its single registered read port; the sequencer steps through these states:
//   append, and any request to an empty ring: DISPATCH, DONE
//   pop: DISPATCH, POP_RD, DONE; find by sequence: DISPATCH, SEQ_FRONT, SEQ_BACK,
//   SEQ_CHECK, SEQ_STEP, FETCH, DONE, leaving for DONE once the key is out of range
//   find by timestamp: DISPATCH, TS_LOOP and TS_CMP repeated until one position
//   is left, FETCH, DONE. s_tready rises in the cycle after the result moves to the output register.
// Reset empties the ring and clears batch_size_log2; the RAM is not cleared,
//   only data read from occupied slots is ever used.
// When m_tready stays low the result holds in the output register; one more
//   request is processed and its result waits in the sequencer, after which
//   s_tready stays low.
module chunk_ring_index_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [223:0] s_tdata, // chunk_handle, first_sequence, first_time, search_key
	input logic [1:0] s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // found_handle
	output logic [1:0] m_tuser, // status
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [4:0] cfg_data
);
	import cri_pkg::*;

	logic [LOG2_W-1:0] batch_log2_q;
	item_t in_item;
	mem_req_t mem_req;
	rec_t rd_rec;
	logic res_valid, res_ready;
	res_t res;
	stat_t stat;
	logic m_valid_q;
	res_t m_res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_log2_q <= '0;
		end else if (cfg_valid) begin
			batch_log2_q <= cfg_data;
		end
	end

	assign in_item.kind = s_tuser;
	assign in_item.handle = s_tdata[31:0];
	assign in_item.seq = s_tdata[95:32];
	assign in_item.stamp = s_tdata[159:96];
	assign in_item.key = s_tdata[223:160];

	cri_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.raddr(mem_req.raddr),
		.rdata(rd_rec)
	);

	cri_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(in_item),
		.batch_log2(batch_log2_q),
		.mem_req(mem_req),
		.rd_rec(rd_rec),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.stat(stat)
	);

	// Output register decouples the sequencer from the receiver
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_res_q.handle;
	assign m_tuser = m_res_q.status;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (stat.busy && !s_tready))
		else $error("sequencer idle after accepting a word");

	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
		else $error("nonzero handle on a failed request");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_EMPTY) |-> (stat.fill == '0))
		else $error("empty status with records held");

endmodule
